@@ src/ica_pkg.sv @@
`default_nettype none
package ica_pkg;

    localparam int unsigned DATA_W      = 64;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned DIV_STEPS   = 64;
    localparam int unsigned STEP_W      = 6;

    localparam logic [63:0] MIN_64 = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MIN_32 = 64'hFFFF_FFFF_8000_0000;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,
        OP_SUB   = 5'd1,
        OP_MUL   = 5'd2,
        OP_DIV   = 5'd3,
        OP_UDIV  = 5'd4,
        OP_REM   = 5'd5,
        OP_UREM  = 5'd6,
        OP_AND   = 5'd7,
        OP_OR    = 5'd8,
        OP_XOR   = 5'd9,
        OP_SHL   = 5'd10,
        OP_SHR   = 5'd11,
        OP_SAR   = 5'd12,
        OP_NEG   = 5'd13,
        OP_SEXT  = 5'd14,
        OP_ZEXT  = 5'd15,
        OP_TRUNC = 5'd16,
        OP_EQ    = 5'd17,
        OP_NE    = 5'd18,
        OP_SLT   = 5'd19,
        OP_SLE   = 5'd20,
        OP_SGT   = 5'd21,
        OP_SGE   = 5'd22,
        OP_ULT   = 5'd23,
        OP_ULE   = 5'd24,
        OP_UGT   = 5'd25,
        OP_UGE   = 5'd26
    } op_t;

    typedef enum logic [1:0] {
        KIND_SIMPLE = 2'd0,
        KIND_MUL    = 2'd1,
        KIND_DIV    = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        BK_IDLE = 2'd0,
        BK_MUL  = 2'd1,
        BK_DIV  = 2'd2,
        BK_DONE = 2'd3
    } bk_state_t;

    localparam logic [1:0] SW_8  = 2'd0;
    localparam logic [1:0] SW_16 = 2'd1;

    // one classified request as it sits in the queue
    typedef struct packed {
        op_t         op;
        kind_t       kind;
        logic        wide;
        logic        bad;
        logic        is_cmp;
        logic        want_rem;
        logic        neg_res;
        logic [1:0]  src_w;
        logic [5:0]  shamt;
        logic [63:0] a;
        logic [63:0] b;
    } entry_t;

    function automatic logic [63:0] sext32(logic [63:0] v);
        return {{32{v[31]}}, v[31:0]};
    endfunction

    function automatic logic [63:0] fold_result(logic [63:0] x, logic bad,
                                                logic is_cmp, logic wide);
        logic [63:0] r;
        if (bad) begin
            r = '0;
        end else if (is_cmp || wide) begin
            r = x;
        end else begin
            r = sext32(x);
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ src/ica_front.sv @@
`default_nettype none
module ica_front (
    input  wire logic [4:0]    action,
    input  wire logic          wide,
    input  wire logic [63:0]   left_value,
    input  wire logic [63:0]   right_value,
    input  wire logic [1:0]    source_width,
    output ica_pkg::entry_t    entry
);

    logic [63:0] l;
    logic [63:0] r;
    logic [63:0] l_mag;
    logic [63:0] r_mag;
    logic [63:0] lu32;
    logic [63:0] ru32;
    logic        r_zero;
    ica_pkg::op_t op;

    assign op     = ica_pkg::op_t'(action);
    assign l      = wide ? left_value  : ica_pkg::sext32(left_value);
    assign r      = wide ? right_value : ica_pkg::sext32(right_value);
    assign lu32   = {32'd0, left_value[31:0]};
    assign ru32   = {32'd0, right_value[31:0]};
    assign l_mag  = l[63] ? (64'd0 - l) : l;
    assign r_mag  = r[63] ? (64'd0 - r) : r;
    assign r_zero = (r == 64'd0);

    always_comb begin
        entry          = '0;
        entry.op       = op;
        entry.kind     = ica_pkg::KIND_SIMPLE;
        entry.wide     = wide;
        entry.src_w    = source_width;
        entry.shamt    = wide ? r[5:0] : {1'b0, r[4:0]};
        entry.a        = l;
        entry.b        = r;
        unique case (op)
            ica_pkg::OP_MUL: begin
                entry.kind = ica_pkg::KIND_MUL;
            end
            ica_pkg::OP_DIV: begin
                entry.bad     = r_zero || ((r == '1) &&
                                (l == (wide ? ica_pkg::MIN_64 : ica_pkg::MIN_32)));
                entry.kind    = ica_pkg::KIND_DIV;
                entry.a       = l_mag;
                entry.b       = r_mag;
                entry.neg_res = l[63] ^ r[63];
            end
            ica_pkg::OP_REM: begin
                entry.bad      = r_zero;
                entry.kind     = ica_pkg::KIND_DIV;
                entry.a        = l_mag;
                entry.b        = r_mag;
                entry.neg_res  = l[63];
                entry.want_rem = 1'b1;
            end
            ica_pkg::OP_UDIV, ica_pkg::OP_UREM: begin
                entry.bad      = r_zero;
                entry.kind     = ica_pkg::KIND_DIV;
                entry.a        = wide ? l : lu32;
                entry.b        = wide ? r : ru32;
                entry.want_rem = (op == ica_pkg::OP_UREM);
            end
            ica_pkg::OP_SHR: begin
                entry.a = wide ? l : lu32;
            end
            ica_pkg::OP_ADD, ica_pkg::OP_SUB, ica_pkg::OP_AND, ica_pkg::OP_OR,
            ica_pkg::OP_XOR, ica_pkg::OP_SHL, ica_pkg::OP_SAR, ica_pkg::OP_NEG,
            ica_pkg::OP_SEXT, ica_pkg::OP_ZEXT, ica_pkg::OP_TRUNC: begin
                entry.kind = ica_pkg::KIND_SIMPLE;
            end
            ica_pkg::OP_EQ, ica_pkg::OP_NE, ica_pkg::OP_SLT, ica_pkg::OP_SLE,
            ica_pkg::OP_SGT, ica_pkg::OP_SGE, ica_pkg::OP_ULT, ica_pkg::OP_ULE,
            ica_pkg::OP_UGT, ica_pkg::OP_UGE: begin
                // compares see the raw operands
                entry.is_cmp = 1'b1;
                entry.a      = left_value;
                entry.b      = right_value;
            end
            default: begin
                entry.bad = 1'b1;
            end
        endcase
        // a request that cannot fold needs no unit
        if (entry.bad) begin
            entry.kind = ica_pkg::KIND_SIMPLE;
        end
    end

endmodule
`default_nettype wire

@@ src/ica_queue.sv @@
`default_nettype none
module ica_queue #(
    parameter int unsigned DEPTH = ica_pkg::QUEUE_DEPTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire ica_pkg::entry_t  push_data,
    output logic                  full,
    input  wire logic             pop,
    output logic                  head_valid,
    output ica_pkg::entry_t       head
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    ica_pkg::entry_t  slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full       = (count_reg == FULL_CNT);
    assign head_valid = (count_reg != '0);
    assign head       = slot_reg[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

@@ src/ica_back.sv @@
`default_nettype none
module ica_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             head_valid,
    input  wire ica_pkg::entry_t  head,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [63:0]           m_result_bits,
    output logic                  m_not_foldable
);

    ica_pkg::bk_state_t state_reg, state_next;
    ica_pkg::entry_t    cur_reg, cur_next;
    logic [ica_pkg::STEP_W-1:0] cnt_reg, cnt_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] prod_reg, prod_next;
    logic        m_valid_reg, m_valid_next;
    logic [63:0] m_result_reg, m_result_next;
    logic        m_nf_reg, m_nf_next;
    logic        out_free;
    logic        load_out;
    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [64:0] trial;
    logic [63:0] div_mag;
    logic [63:0] unit_x;

    function automatic logic [63:0] simple_result(ica_pkg::entry_t e);
        logic [63:0] x;
        x = '0;
        case (e.op)
            ica_pkg::OP_ADD:   x = e.a + e.b;
            ica_pkg::OP_SUB:   x = e.a - e.b;
            ica_pkg::OP_AND:   x = e.a & e.b;
            ica_pkg::OP_OR:    x = e.a | e.b;
            ica_pkg::OP_XOR:   x = e.a ^ e.b;
            ica_pkg::OP_SHL:   x = e.a << e.shamt;
            ica_pkg::OP_SHR:   x = e.a >> e.shamt;
            ica_pkg::OP_SAR:   x = $unsigned($signed(e.a) >>> e.shamt);
            ica_pkg::OP_NEG:   x = 64'd0 - e.a;
            ica_pkg::OP_SEXT: begin
                case (e.src_w)
                    ica_pkg::SW_8:  x = {{56{e.a[7]}}, e.a[7:0]};
                    ica_pkg::SW_16: x = {{48{e.a[15]}}, e.a[15:0]};
                    default:        x = ica_pkg::sext32(e.a);
                endcase
            end
            ica_pkg::OP_ZEXT, ica_pkg::OP_TRUNC: x = e.a;
            ica_pkg::OP_EQ:  x = {63'd0, e.a == e.b};
            ica_pkg::OP_NE:  x = {63'd0, e.a != e.b};
            ica_pkg::OP_SLT: x = {63'd0, $signed(e.a) <  $signed(e.b)};
            ica_pkg::OP_SLE: x = {63'd0, $signed(e.a) <= $signed(e.b)};
            ica_pkg::OP_SGT: x = {63'd0, $signed(e.a) >  $signed(e.b)};
            ica_pkg::OP_SGE: x = {63'd0, $signed(e.a) >= $signed(e.b)};
            ica_pkg::OP_ULT: x = {63'd0, e.a <  e.b};
            ica_pkg::OP_ULE: x = {63'd0, e.a <= e.b};
            ica_pkg::OP_UGT: x = {63'd0, e.a >  e.b};
            ica_pkg::OP_UGE: x = {63'd0, e.a >= e.b};
            default:         x = '0;
        endcase
        return x;
    endfunction

    assign out_free = !m_valid_reg || m_ready;

    // low 64 bits of the product from three 32x32 partial products
    assign mul_a = (cnt_reg[1:0] == 2'd2) ? cur_reg.a[63:32] : cur_reg.a[31:0];
    assign mul_b = (cnt_reg[1:0] == 2'd1) ? cur_reg.b[63:32] : cur_reg.b[31:0];

    // restoring divide, one quotient bit per step
    assign trial   = {rem_reg, acc_reg[63]} - {1'b0, cur_reg.b};
    assign div_mag = cur_reg.want_rem ? rem_reg : acc_reg;
    assign unit_x  = (cur_reg.kind == ica_pkg::KIND_MUL) ? acc_reg :
                     (cur_reg.neg_res ? (64'd0 - div_mag) : div_mag);

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ica_pkg::BK_IDLE: begin
                if (head_valid && head.kind == ica_pkg::KIND_MUL) begin
                    state_next = ica_pkg::BK_MUL;
                end else if (head_valid && head.kind == ica_pkg::KIND_DIV) begin
                    state_next = ica_pkg::BK_DIV;
                end
            end
            ica_pkg::BK_MUL: begin
                if (cnt_reg[1:0] == 2'd3) begin
                    state_next = ica_pkg::BK_DONE;
                end
            end
            ica_pkg::BK_DIV: begin
                if (cnt_reg == ica_pkg::STEP_W'(ica_pkg::DIV_STEPS - 1)) begin
                    state_next = ica_pkg::BK_DONE;
                end
            end
            ica_pkg::BK_DONE: begin
                if (out_free) begin
                    state_next = ica_pkg::BK_IDLE;
                end
            end
            default: state_next = ica_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        pop           = 1'b0;
        load_out      = 1'b0;
        m_result_next = m_result_reg;
        m_nf_next     = m_nf_reg;
        cur_next      = cur_reg;
        cnt_next      = cnt_reg;
        acc_next      = acc_reg;
        rem_next      = rem_reg;
        prod_next     = prod_reg;
        unique case (state_reg)
            ica_pkg::BK_IDLE: begin
                if (head_valid && head.kind == ica_pkg::KIND_SIMPLE) begin
                    if (out_free) begin
                        pop           = 1'b1;
                        load_out      = 1'b1;
                        m_result_next = ica_pkg::fold_result(simple_result(head),
                                            head.bad, head.is_cmp, head.wide);
                        m_nf_next     = head.bad;
                    end
                end else if (head_valid) begin
                    pop      = 1'b1;
                    cur_next = head;
                    cnt_next = '0;
                    acc_next = head.a;
                    rem_next = '0;
                end
            end
            ica_pkg::BK_MUL: begin
                prod_next = mul_a * mul_b;
                cnt_next  = cnt_reg + 1'b1;
                if (cnt_reg[1:0] == 2'd1) begin
                    acc_next = prod_reg;
                end else if (cnt_reg[1:0] != 2'd0) begin
                    acc_next = acc_reg + {prod_reg[31:0], 32'd0};
                end
            end
            ica_pkg::BK_DIV: begin
                cnt_next = cnt_reg + 1'b1;
                if (!trial[64]) begin
                    rem_next = trial[63:0];
                    acc_next = {acc_reg[62:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[62:0], acc_reg[63]};
                    acc_next = {acc_reg[62:0], 1'b0};
                end
            end
            ica_pkg::BK_DONE: begin
                if (out_free) begin
                    load_out      = 1'b1;
                    m_result_next = ica_pkg::fold_result(unit_x, 1'b0, 1'b0,
                                                         cur_reg.wide);
                    m_nf_next     = 1'b0;
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
        m_valid_next = load_out ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ica_pkg::BK_IDLE;
            m_valid_reg <= 1'b0;
            cnt_reg     <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            cnt_reg     <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg      <= cur_next;
        acc_reg      <= acc_next;
        rem_reg      <= rem_next;
        prod_reg     <= prod_next;
        m_result_reg <= m_result_next;
        m_nf_reg     <= m_nf_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_result_bits  = m_result_reg;
    assign m_not_foldable = m_nf_reg;

endmodule
`default_nettype wire

@@ src/integer_constant_alu.sv @@
// integer constant alu: one integer operation per request, 32-bit or 64-bit
// mode, one result per request in request order. add, sub, logic ops, shifts,
// neg, sext, zext, trunc and the ten compares are popped and their result is
// loaded in the same cycle, so these stream at one request per clock while
// the result register is free. mul goes through pop, four multiplier steps
// with three 32x32 partial products through one shared multiplier and result
// load; div, udiv, rem and urem go through pop, a restoring divider with one
// quotient bit per clock and result load, and the execute unit holds one such
// request at a time. a two-entry queue between decode and execute lets
// s_ready stay high while execute works or the result register waits for
// m_ready, until the queue fills. not_foldable is set, with a zero result, on
// a zero divisor, on signed min / -1 division and on unknown opcodes
`default_nettype none
module integer_constant_alu #(
    parameter int unsigned QUEUE_DEPTH = ica_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // request channel
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [4:0]  s_action,
    input  wire logic        s_wide,
    input  wire logic [63:0] s_left_value,
    input  wire logic [63:0] s_right_value,
    input  wire logic [1:0]  s_source_width,
    // result channel
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [63:0]      m_result_bits,
    output logic             m_not_foldable
);

    ica_pkg::entry_t front_entry;
    ica_pkg::entry_t head;
    logic            q_full;
    logic            head_valid;
    logic            pop;

    // decode: narrowing, operand magnitudes, fold checks
    ica_front u_front (
        .action       (s_action),
        .wide         (s_wide),
        .left_value   (s_left_value),
        .right_value  (s_right_value),
        .source_width (s_source_width),
        .entry        (front_entry)
    );

    // decoupling queue between decode and execute
    ica_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (s_valid),
        .push_data  (front_entry),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    assign s_ready = !q_full;

    // execute: simple ops, multiplier sequence, divider, result register
    ica_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head           (head),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_result_bits  (m_result_bits),
        .m_not_foldable (m_not_foldable)
    );

endmodule
`default_nettype wire

@@ src/ica_checker.sv @@
`default_nettype none
module ica_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_valid,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [63:0] m_result_bits,
    input wire logic        m_not_foldable
);

    // no result right after reset
    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // a request that cannot fold carries a zero result
    a_nf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_not_foldable |-> m_result_bits == 64'd0)
        else $error("not foldable with nonzero result");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result_bits)
                                && $stable(m_not_foldable))
        else $error("stalled result changed");

    // nothing comes out of an empty block: no result just after reset when no request is taken
    a_first: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) && !(s_valid && s_ready) |=> !m_valid)
        else $error("result without request");

endmodule

bind integer_constant_alu ica_checker u_ica_checker (.*);
`default_nettype wire

@@ verif/integer_constant_alu_test.sv @@
`default_nettype none
module integer_constant_alu_test;

    // one folded result as the block should report it
    typedef struct {
        logic [63:0] bits;
        logic        nf;
    } fold_t;

    class fold_board;
        fold_t pending[$];
        int    errors;

        function automatic logic [63:0] narrow(logic [63:0] v, int unsigned n);
            logic [63:0] m;
            logic [63:0] s;
            m = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
            s = 64'd1 << (n - 1);
            return ((v & m) ^ s) - s;
        endfunction

        // signed quotient or remainder on magnitudes, divisor nonzero
        function automatic logic [63:0] signed_divide(logic [63:0] a, logic [63:0] b,
                                                      bit want_rem);
            logic [63:0] ma;
            logic [63:0] mb;
            logic [63:0] q;
            ma = a[63] ? -a : a;
            mb = b[63] ? -b : b;
            if (want_rem) begin
                q = ma % mb;
                return a[63] ? -q : q;
            end
            q = ma / mb;
            return (a[63] != b[63]) ? -q : q;
        endfunction

        function automatic fold_t evaluate(logic [4:0] act, logic w, logic [63:0] lr,
                                           logic [63:0] rr, logic [1:0] sw);
            fold_t       f;
            logic [63:0] l;
            logic [63:0] r;
            logic [63:0] lu;
            logic [63:0] ru;
            logic [63:0] x;
            logic [5:0]  sh;
            bit          bad;
            bit          cmp;
            l = w ? lr : narrow(lr, 32);
            r = w ? rr : narrow(rr, 32);
            lu = {32'd0, lr[31:0]};
            ru = {32'd0, rr[31:0]};
            sh = w ? r[5:0] : {1'b0, r[4:0]};
            x = '0;
            bad = 0;
            cmp = 0;
            case (act)
                ica_pkg::OP_ADD: x = l + r;
                ica_pkg::OP_SUB: x = l - r;
                ica_pkg::OP_MUL: x = l * r;
                ica_pkg::OP_DIV: begin
                    if (r == 0 || (r == '1 &&
                        l == (w ? ica_pkg::MIN_64 : ica_pkg::MIN_32))) bad = 1;
                    else x = signed_divide(l, r, 0);
                end
                ica_pkg::OP_UDIV: begin
                    if (r == 0) bad = 1;
                    else x = w ? l / r : lu / ru;
                end
                ica_pkg::OP_REM: begin
                    if (r == 0) bad = 1;
                    else x = (r == '1) ? '0 : signed_divide(l, r, 1);
                end
                ica_pkg::OP_UREM: begin
                    if (r == 0) bad = 1;
                    else x = w ? l % r : lu % ru;
                end
                ica_pkg::OP_AND: x = l & r;
                ica_pkg::OP_OR: x = l | r;
                ica_pkg::OP_XOR: x = l ^ r;
                ica_pkg::OP_SHL: x = l << sh;
                ica_pkg::OP_SHR: x = (w ? l : lu) >> sh;
                ica_pkg::OP_SAR: x = $signed(l) >>> sh;
                ica_pkg::OP_NEG: x = -l;
                ica_pkg::OP_SEXT: x = narrow(l, sw == ica_pkg::SW_8 ? 8 :
                                             (sw == ica_pkg::SW_16 ? 16 : 32));
                ica_pkg::OP_ZEXT, ica_pkg::OP_TRUNC: x = l;
                ica_pkg::OP_EQ: begin x = {63'd0, lr == rr}; cmp = 1; end
                ica_pkg::OP_NE: begin x = {63'd0, lr != rr}; cmp = 1; end
                ica_pkg::OP_SLT: begin x = {63'd0, $signed(lr) < $signed(rr)}; cmp = 1; end
                ica_pkg::OP_SLE: begin x = {63'd0, $signed(lr) <= $signed(rr)}; cmp = 1; end
                ica_pkg::OP_SGT: begin x = {63'd0, $signed(lr) > $signed(rr)}; cmp = 1; end
                ica_pkg::OP_SGE: begin x = {63'd0, $signed(lr) >= $signed(rr)}; cmp = 1; end
                ica_pkg::OP_ULT: begin x = {63'd0, lr < rr}; cmp = 1; end
                ica_pkg::OP_ULE: begin x = {63'd0, lr <= rr}; cmp = 1; end
                ica_pkg::OP_UGT: begin x = {63'd0, lr > rr}; cmp = 1; end
                ica_pkg::OP_UGE: begin x = {63'd0, lr >= rr}; cmp = 1; end
                default: bad = 1;
            endcase
            if (bad) x = '0;
            else if (!cmp && !w) x = narrow(x, 32);
            f.bits = x;
            f.nf = bad;
            return f;
        endfunction

        function void note_request(logic [4:0] act, logic w, logic [63:0] lr,
                                   logic [63:0] rr, logic [1:0] sw);
            pending.push_back(evaluate(act, w, lr, rr, sw));
        endfunction

        function void check_result(logic [63:0] bits, logic nf);
            fold_t e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result bits %h nf %b", $time, bits, nf);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (bits !== e.bits) begin
                $display("%0t: result_bits expected %h actual %h", $time, e.bits, bits);
                errors++;
            end
            if (nf !== e.nf) begin
                $display("%0t: not_foldable expected %b actual %b", $time, e.nf, nf);
                errors++;
            end
        endfunction
    endclass

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [4:0]  s_action;
    logic        s_wide;
    logic [63:0] s_left_value;
    logic [63:0] s_right_value;
    logic [1:0]  s_source_width;
    logic        m_valid;
    logic        m_ready;
    logic [63:0] m_result_bits;
    logic        m_not_foldable;

    fold_board board;
    int        send_idle_pct;
    int        take_stall_pct;

    integer_constant_alu u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_wide        (s_wide),
        .s_left_value  (s_left_value),
        .s_right_value (s_right_value),
        .s_source_width(s_source_width),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_result_bits (m_result_bits),
        .m_not_foldable(m_not_foldable)
    );

    // free running clock, period 4
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    // receiver: random ready, results checked at the accepting edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            board.check_result(m_result_bits, m_not_foldable);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= take_stall_pct);
        end
    end

    // operand with a bias toward edge values
    function automatic logic [63:0] pick_operand();
        case ($urandom_range(9))
            0: return 64'd0;
            1: return '1;
            2: return ica_pkg::MIN_64;
            3: return ica_pkg::MIN_32;
            4: return 64'h0000_0000_7FFF_FFFF;
            5: return 64'($urandom_range(70));
            6: return {32'd0, $urandom()};
            7: return {{32{1'b1}}, $urandom()};
            default: return {$urandom(), $urandom()};
        endcase
    endfunction

    // present one request and hold it until the block takes it; valid drops
    // only while the sender idles
    task automatic send_request(logic [4:0] act, logic w, logic [63:0] lr,
                                logic [63:0] rr, logic [1:0] sw);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= act;
        s_wide         <= w;
        s_left_value   <= lr;
        s_right_value  <= rr;
        s_source_width <= sw;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        board.note_request(act, w, lr, rr, sw);
    endtask

    task automatic random_request();
        logic [4:0] act;
        act = ($urandom_range(19) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(26));
        send_request(act, 1'($urandom()), pick_operand(), pick_operand(),
                     2'($urandom_range(3)));
    endtask

    // sender pause until every result is back
    task automatic drain();
        s_valid <= 1'b0;
        while (board.pending.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    initial begin
        board = new();
        send_idle_pct  = 0;
        take_stall_pct = 0;
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_action       = '0;
        s_wide         = 1'b0;
        s_left_value   = '0;
        s_right_value  = '0;
        s_source_width = '0;
        m_ready        = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: a spread of opcodes on 64-bit min and -1, plus corner cases
        for (int op = 0; op < 32; op += 3) begin
            send_request(5'(op), 1'b1, ica_pkg::MIN_64, '1, 2'd3);
        end
        send_request(ica_pkg::OP_DIV, 1'b0, ica_pkg::MIN_32, '1, 2'd0);
        send_request(ica_pkg::OP_DIV, 1'b0, 64'h8000_0000, 64'hFFFF_FFFF, 2'd0);
        send_request(ica_pkg::OP_REM, 1'b1, ica_pkg::MIN_64, '1, 2'd0);
        send_request(ica_pkg::OP_UDIV, 1'b0, 64'd5, 64'h1_0000_0000, 2'd0);
        send_request(ica_pkg::OP_UREM, 1'b1, '1, 64'd0, 2'd0);
        send_request(ica_pkg::OP_SHR, 1'b0, '1, 64'd33, 2'd0);
        send_request(ica_pkg::OP_SAR, 1'b1, ica_pkg::MIN_64, 64'd63, 2'd0);
        send_request(ica_pkg::OP_SEXT, 1'b1, 64'h80, 64'd0, ica_pkg::SW_8);
        send_request(ica_pkg::OP_SEXT, 1'b0, 64'h8000, 64'd0, ica_pkg::SW_16);
        send_request(ica_pkg::OP_SLT, 1'b0, 64'hFFFF_FFFF, 64'd1, 2'd0);
        send_request(5'd31, 1'b0, '1, '1, 2'd3);
        send_request(ica_pkg::OP_MUL, 1'b0, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 2'd2);
        drain();

        // random phases with different idling
        send_idle_pct  = 31;
        take_stall_pct = 71;
        repeat (350) random_request();
        drain();
        send_idle_pct  = 71;
        take_stall_pct = 31;
        repeat (350) random_request();
        send_idle_pct  = 0;
        take_stall_pct = 0;
        repeat (350) random_request();
        drain();
        repeat (80) @(posedge aclk);

        if (board.errors == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // watchdog: a bound on the whole run, stalls included
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
`default_nettype wire
